// ===== hw/rtl/ffaa_pkg.sv =====
// Shared constants, command codes and transfer types of the first-fit arena allocator.
package ffaa_pkg;

    localparam int ARENA_BYTES  = 8192;
    localparam int HEADER_BYTES = 24;
    localparam int ARENA_MIN    = 100;
    localparam int ADDR_W       = $clog2(ARENA_BYTES);
    localparam int SIZE_W       = 14;
    localparam int HDR_W        = SIZE_W + 1;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INFO  = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [SIZE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic              status;
        logic [12:0]       offset;
        logic [SIZE_W-1:0] used_blocks;
        logic [SIZE_W-1:0] allocated_bytes;
        logic [SIZE_W-1:0] largest_free;
    } out_t;

    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } hdr_t;

endpackage

// ===== hw/rtl/first_fit_arena_allocator.sv =====
// First-fit arena allocator: header walk over a block header RAM with coalescing on free.
//
//  channel   signals                      direction  content
//  in        in_valid/in_stall/in_data    to block   command, value
//  out       out_valid/out_stall/out_data from block status, offset, counters, largest free
//  cfg       cfg_valid/cfg_ready/cfg_data to block   arena_size
//
// Each block header visited takes a RAM read state, then a check state. An allocation
// that splits adds a split write state, a free of a block that is not the last adds a
// merge write state, and the result may wait for the output register; the walk is
// bounded by the blocks in the arena. After reset and after each arena_size write the
// block writes the first header in its init state. A stalled result holds in the output
// register; the next command is accepted once the current result is loaded there.
module first_fit_arena_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffaa_pkg::in_t       in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ffaa_pkg::out_t      out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ffaa_pkg::SIZE_W-1:0] cfg_data
);

    localparam int AW = ffaa_pkg::ADDR_W;
    localparam int SW = ffaa_pkg::SIZE_W;
    localparam logic [SW:0]   HDR15 = (SW+1)'(ffaa_pkg::HEADER_BYTES);
    localparam logic [SW-1:0] HDR14 = SW'(ffaa_pkg::HEADER_BYTES);
    localparam logic [SW:0]   SPLIT_MARGIN = (SW+1)'(2 * ffaa_pkg::HEADER_BYTES);
    localparam logic [SW-1:0] ARENA_MAX = SW'(ffaa_pkg::ARENA_BYTES);
    localparam logic [SW-1:0] ARENA_LOW = SW'(ffaa_pkg::ARENA_MIN);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CK    = 3'd3;
    localparam logic [2:0] ST_SPLIT = 3'd4;
    localparam logic [2:0] ST_FNX   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [SW-1:0]       val_reg, val_next;
    logic [AW-1:0]       off_reg, off_next;
    logic [AW-1:0]       prev_off_reg, prev_off_next;
    ffaa_pkg::hdr_t      prev_hdr_reg, prev_hdr_next;
    logic                has_prev_reg, has_prev_next;
    logic [SW-1:0]       best_reg, best_next;
    logic [AW-1:0]       base_off_reg, base_off_next;
    logic [SW-1:0]       base_size_reg, base_size_next;
    logic [AW-1:0]       split_off_reg, split_off_next;
    logic [SW-1:0]       split_size_reg, split_size_next;
    logic [SW-1:0]       arena_reg, arena_next;
    logic [SW-1:0]       used_reg, used_next;
    logic [SW-1:0]       alloc_reg, alloc_next;
    logic [SW-1:0]       ftot_reg, ftot_next;
    logic                res_status_reg, res_status_next;
    logic [AW-1:0]       res_where_reg, res_where_next;
    logic [SW-1:0]       res_largest_reg, res_largest_next;
    logic                out_valid_reg, out_valid_next;
    ffaa_pkg::out_t      out_data_reg, out_data_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    ffaa_pkg::hdr_t      wr_hdr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [SW:0]         rd_raw;
    ffaa_pkg::hdr_t      hdr;
    logic [SW:0]         nxt;
    logic                last;
    logic                merge_prev;
    logic [SW-1:0]       arena_clamped;

    ffaa_ram #(
        .WIDTH (ffaa_pkg::HDR_W),
        .DEPTH (ffaa_pkg::ARENA_BYTES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_hdr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign hdr        = rd_raw;
    assign nxt        = {{(SW+1-AW){1'b0}}, off_reg} + HDR15 + {1'b0, hdr.size};
    assign last       = nxt >= {1'b0, arena_reg};
    assign merge_prev = has_prev_reg && prev_hdr_reg.is_free;

    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (cfg_data < ARENA_LOW)
        begin
            arena_clamped = ARENA_LOW;
        end
        else if (cfg_data > ARENA_MAX)
        begin
            arena_clamped = ARENA_MAX;
        end
        else
        begin
            arena_clamped = cfg_data;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        val_next         = val_reg;
        off_next         = off_reg;
        prev_off_next    = prev_off_reg;
        prev_hdr_next    = prev_hdr_reg;
        has_prev_next    = has_prev_reg;
        best_next        = best_reg;
        base_off_next    = base_off_reg;
        base_size_next   = base_size_reg;
        split_off_next   = split_off_reg;
        split_size_next  = split_size_reg;
        arena_next       = arena_reg;
        used_next        = used_reg;
        alloc_next       = alloc_reg;
        ftot_next        = ftot_reg;
        res_status_next  = res_status_reg;
        res_where_next   = res_where_reg;
        res_largest_next = res_largest_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        wr_en            = 1'b0;
        wr_addr          = off_reg;
        wr_hdr           = '0;
        rd_en            = 1'b0;
        rd_addr          = off_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_hdr.is_free = 1'b1;
                wr_hdr.size    = arena_reg - HDR14;
                ftot_next      = arena_reg - HDR14;
                used_next      = '0;
                alloc_next     = '0;
                state_next     = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    arena_next = arena_clamped;
                    state_next = ST_INIT;
                end
                else if (in_valid)
                begin
                    cmd_next         = in_data.command;
                    val_next         = in_data.value;
                    off_next         = '0;
                    has_prev_next    = 1'b0;
                    best_next        = '0;
                    res_status_next  = 1'b1;
                    res_where_next   = '0;
                    res_largest_next = '0;
                    if (in_data.command != ffaa_pkg::CMD_ALLOC &&
                        in_data.command != ffaa_pkg::CMD_FREE &&
                        in_data.command != ffaa_pkg::CMD_INFO)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (in_data.command == ffaa_pkg::CMD_ALLOC &&
                             ftot_reg < in_data.value)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = off_reg;
                state_next = ST_CK;
            end
            ST_CK:
            begin
                case (cmd_reg)
                    ffaa_pkg::CMD_ALLOC:
                    begin
                        if (hdr.is_free && hdr.size >= val_reg)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = off_reg;
                            wr_hdr.is_free  = 1'b0;
                            used_next       = used_reg + 1'b1;
                            res_status_next = 1'b0;
                            res_where_next  = off_reg;
                            if ({1'b0, hdr.size} > {1'b0, val_reg} + SPLIT_MARGIN)
                            begin
                                wr_hdr.size     = val_reg;
                                split_off_next  = AW'({{(SW+1-AW){1'b0}}, off_reg} + HDR15
                                                      + {1'b0, val_reg});
                                split_size_next = hdr.size - val_reg - HDR14;
                                ftot_next       = ftot_reg - val_reg - HDR14;
                                alloc_next      = alloc_reg + val_reg;
                                state_next      = ST_SPLIT;
                            end
                            else
                            begin
                                wr_hdr.size = hdr.size;
                                ftot_next   = ftot_reg - hdr.size;
                                alloc_next  = alloc_reg + hdr.size;
                                state_next  = ST_DONE;
                            end
                        end
                        else if (last)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            off_next   = nxt[AW-1:0];
                            state_next = ST_RD;
                        end
                    end
                    ffaa_pkg::CMD_FREE:
                    begin
                        if ({{(SW-AW){1'b0}}, off_reg} == val_reg)
                        begin
                            if (hdr.is_free)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                res_status_next = 1'b0;
                                used_next       = used_reg - 1'b1;
                                alloc_next      = alloc_reg - hdr.size;
                                if (merge_prev)
                                begin
                                    ftot_next      = ftot_reg + hdr.size + HDR14;
                                    base_off_next  = prev_off_reg;
                                    base_size_next = prev_hdr_reg.size + hdr.size + HDR14;
                                end
                                else
                                begin
                                    ftot_next      = ftot_reg + hdr.size;
                                    base_off_next  = off_reg;
                                    base_size_next = hdr.size;
                                end
                                if (last)
                                begin
                                    wr_en          = 1'b1;
                                    wr_addr        = merge_prev ? prev_off_reg : off_reg;
                                    wr_hdr.is_free = 1'b1;
                                    wr_hdr.size    = base_size_next;
                                    state_next     = ST_DONE;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = nxt[AW-1:0];
                                    state_next = ST_FNX;
                                end
                            end
                        end
                        else if (last)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            prev_off_next = off_reg;
                            prev_hdr_next = hdr;
                            has_prev_next = 1'b1;
                            off_next      = nxt[AW-1:0];
                            state_next    = ST_RD;
                        end
                    end
                    default:
                    begin
                        if (hdr.is_free && hdr.size > best_reg)
                        begin
                            best_next = hdr.size;
                        end
                        if (last)
                        begin
                            res_status_next  = 1'b0;
                            res_largest_next = best_next;
                            state_next       = ST_DONE;
                        end
                        else
                        begin
                            off_next   = nxt[AW-1:0];
                            state_next = ST_RD;
                        end
                    end
                endcase
            end
            ST_SPLIT:
            begin
                wr_en          = 1'b1;
                wr_addr        = split_off_reg;
                wr_hdr.is_free = 1'b1;
                wr_hdr.size    = split_size_reg;
                state_next     = ST_DONE;
            end
            ST_FNX:
            begin
                wr_en          = 1'b1;
                wr_addr        = base_off_reg;
                wr_hdr.is_free = 1'b1;
                if (hdr.is_free)
                begin
                    wr_hdr.size = base_size_reg + hdr.size + HDR14;
                    ftot_next   = ftot_reg + HDR14;
                end
                else
                begin
                    wr_hdr.size = base_size_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.status          = res_status_reg;
                    out_data_next.offset          = res_where_reg;
                    out_data_next.used_blocks     = used_reg;
                    out_data_next.allocated_bytes = alloc_reg;
                    out_data_next.largest_free    = res_largest_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            arena_reg     <= ARENA_MAX;
            used_reg      <= '0;
            alloc_reg     <= '0;
            ftot_reg      <= ARENA_MAX - HDR14;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arena_reg     <= arena_next;
            used_reg      <= used_next;
            alloc_reg     <= alloc_next;
            ftot_reg      <= ftot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        val_reg         <= val_next;
        off_reg         <= off_next;
        prev_off_reg    <= prev_off_next;
        prev_hdr_reg    <= prev_hdr_next;
        has_prev_reg    <= has_prev_next;
        best_reg        <= best_next;
        base_off_reg    <= base_off_next;
        base_size_reg   <= base_size_next;
        split_off_reg   <= split_off_next;
        split_size_reg  <= split_size_next;
        res_status_reg  <= res_status_next;
        res_where_reg   <= res_where_next;
        res_largest_reg <= res_largest_next;
        out_data_reg    <= out_data_next;
    end

endmodule

// ===== hw/rtl/ffaa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ffaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ffaa_checker.sv =====
// Port-level checks of the first-fit arena allocator and their binding to the top level.
module ffaa_props (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ffaa_pkg::in_t       in_data,
    input logic                out_valid,
    input logic                out_stall,
    input ffaa_pkg::out_t      out_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [ffaa_pkg::SIZE_W-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.offset == '0)
        else $error("failed command carries an offset");

    a_largest_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.largest_free != '0 |-> !out_data.status)
        else $error("largest free reported on a failure");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

    a_cfg_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready && in_stall)
        else $error("arena not reinitialised after configuration");

endmodule

bind first_fit_arena_allocator ffaa_props u_ffaa_checker (.*);

// ===== tb/ffaa_checker.sv =====
// Checker for the first-fit arena allocator: watches the channels, predicts results and compares.
module ffaa_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  ffaa_pkg::in_t              in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  ffaa_pkg::out_t             out_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ffaa_pkg::SIZE_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending,
    output int                         result_count
);

    localparam int SW = ffaa_pkg::SIZE_W;
    localparam int HB = ffaa_pkg::HEADER_BYTES;
    localparam int AB = ffaa_pkg::ARENA_BYTES;

    int unsigned     arena_len;
    int unsigned     blk_size [AB];
    bit              blk_is_free [AB];
    int unsigned     used_n;
    int unsigned     alloc_sum;
    int unsigned     free_sum;
    ffaa_pkg::out_t  expected_q [$];

    function automatic int unsigned next_of(int unsigned off);
        return off + HB + (off < AB ? blk_size[off] : 0);
    endfunction

    function automatic bit is_last(int unsigned off);
        return next_of(off) >= arena_len;
    endfunction

    function automatic bit free_at(int unsigned off);
        return off < AB && blk_is_free[off];
    endfunction

    function automatic int unsigned size_at(int unsigned off);
        return off < AB ? blk_size[off] : 0;
    endfunction

    function automatic void put_hdr(int unsigned off, int unsigned sz, bit fr);
        if (off < AB)
        begin
            blk_size[off] = sz & 20'hFFFFF;
            blk_is_free[off] = fr;
        end
    endfunction

    function automatic void arena_clear(int unsigned len);
        arena_len = len;
        foreach (blk_size[i])
        begin
            blk_size[i] = 0;
            blk_is_free[i] = 0;
        end
        used_n = 0;
        alloc_sum = 0;
        free_sum = len - HB;
        put_hdr(0, free_sum, 1);
    endfunction

    function automatic bit try_alloc(int unsigned req, output int unsigned where);
        int unsigned off;
        int unsigned sz;
        off = 0;
        where = 0;
        if (free_sum < req)
            return 0;
        while (!(free_at(off) && size_at(off) >= req) && !is_last(off))
            off = next_of(off);
        sz = size_at(off);
        if (!(free_at(off) && sz >= req))
            return 0;
        if (sz > req + 2 * HB)
        begin
            put_hdr(off, req, 0);
            put_hdr(off + HB + req, sz - req - HB, 1);
            free_sum -= req + HB;
            sz = req;
        end
        else
        begin
            put_hdr(off, sz, 0);
            free_sum -= sz;
        end
        used_n++;
        alloc_sum += sz;
        where = off;
        return 1;
    endfunction

    function automatic bit try_release(int unsigned pos);
        int unsigned off;
        int unsigned prev;
        int unsigned sz;
        int unsigned nxt;
        bit has_prev;
        off = 0;
        prev = 0;
        has_prev = 0;
        while (off != pos && !is_last(off))
        begin
            prev = off;
            has_prev = 1;
            off = next_of(off);
        end
        if (off != pos || free_at(off))
            return 0;
        sz = size_at(off);
        put_hdr(off, sz, 1);
        used_n--;
        alloc_sum -= sz;
        free_sum += sz;
        if (has_prev && free_at(prev))
        begin
            put_hdr(prev, size_at(prev) + sz + HB, 1);
            free_sum += HB;
            put_hdr(off, 0, 0);
            off = prev;
        end
        if (!is_last(off))
        begin
            nxt = next_of(off);
            if (free_at(nxt))
            begin
                put_hdr(off, size_at(off) + size_at(nxt) + HB, 1);
                free_sum += HB;
                put_hdr(nxt, 0, 0);
            end
        end
        return 1;
    endfunction

    function automatic int unsigned widest_free();
        int unsigned off;
        int unsigned best;
        off = 0;
        best = 0;
        forever
        begin
            if (free_at(off) && size_at(off) > best)
                best = size_at(off);
            if (is_last(off))
                break;
            off = next_of(off);
        end
        return best;
    endfunction

    function automatic ffaa_pkg::out_t predict_result(ffaa_pkg::in_t item);
        ffaa_pkg::out_t r;
        int unsigned    where;
        int unsigned    best;
        r = '0;
        r.status = 1'b1;
        where = 0;
        case (item.command)
            ffaa_pkg::CMD_ALLOC: if (try_alloc(item.value, where)) r.status = 1'b0;
            ffaa_pkg::CMD_FREE:  if (try_release(item.value)) r.status = 1'b0;
            ffaa_pkg::CMD_INFO:
            begin
                best = widest_free();
                r.largest_free = best[SW-1:0];
                r.status = 1'b0;
            end
            default: ;
        endcase
        r.offset = where[12:0];
        r.used_blocks = used_n[SW-1:0];
        r.allocated_bytes = alloc_sum[SW-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned    v;
        ffaa_pkg::out_t exp_r;
        if (!rst_n)
        begin
            arena_clear(AB);
            expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                v = cfg_data;
                if (v < ffaa_pkg::ARENA_MIN)
                    v = ffaa_pkg::ARENA_MIN;
                if (v > AB)
                    v = AB;
                arena_clear(v);
            end
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== out_data)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(predict_result(in_data));
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb_first_fit_arena_allocator.sv =====
// Testbench top for the first-fit arena allocator: stimulus, idling, pressure and verdict.
module tb_first_fit_arena_allocator;

    localparam int SW = ffaa_pkg::SIZE_W;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    ffaa_pkg::in_t     in_data = '0;
    logic              out_valid;
    logic              out_stall = 0;
    ffaa_pkg::out_t    out_data;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [SW-1:0]     cfg_data = '0;
    int                fail_count;
    int                pending;
    int                result_count;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                long_hold = 0;
    int                hold_cnt = 0;
    int                quiet_cycles = 0;
    int                item_count = 0;
    int unsigned       live_offs [$];
    int unsigned       cur_arena = ffaa_pkg::ARENA_BYTES;
    ffaa_pkg::in_t     cmd_q [$];

    always #6 clk = ~clk;

    first_fit_arena_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    ffaa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always @(posedge clk)
    begin
        if (long_hold && hold_cnt < 400)
        begin
            hold_cnt <= hold_cnt + 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("timeout with %0d results outstanding", pending);
            $display("FAIL first_fit_arena_allocator");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        ffaa_pkg::in_t done_cmd;
        if (out_valid && !out_stall && cmd_q.size() > 0)
        begin
            done_cmd = cmd_q.pop_front();
            if (done_cmd.command == ffaa_pkg::CMD_ALLOC && !out_data.status)
                live_offs.push_back(out_data.offset);
        end
        if (in_valid && !in_stall)
            cmd_q.push_back(in_data);
    end

    task automatic send(logic [1:0] cmd, logic [SW-1:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= '{command: cmd, value: val};
        do
            @(posedge clk);
        while (in_stall);
        item_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_arena(logic [SW-1:0] sz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= sz;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_arena = (sz < ffaa_pkg::ARENA_MIN) ? ffaa_pkg::ARENA_MIN :
                    (sz > ffaa_pkg::ARENA_BYTES ? ffaa_pkg::ARENA_BYTES : sz);
        live_offs.delete();
        @(posedge clk);
    endtask

    function automatic logic [SW-1:0] pick_size();
        case ($urandom_range(9))
            0: return SW'($urandom_range((1 << SW) - 1));
            1: return '0;
            2, 3: return SW'($urandom_range(cur_arena));
            default: return SW'($urandom_range(cur_arena / 8 + 1));
        endcase
    endfunction

    task automatic random_phase(int n);
        int idx;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: send(ffaa_pkg::CMD_ALLOC, pick_size());
                8, 9, 10, 11, 12, 13, 14:
                    if (live_offs.size() > 0)
                    begin
                        idx = $urandom_range(live_offs.size() - 1);
                        send(ffaa_pkg::CMD_FREE, SW'(live_offs[idx]));
                        live_offs.delete(idx);
                    end
                    else
                        send(ffaa_pkg::CMD_FREE, SW'($urandom_range(cur_arena)));
                15: send(ffaa_pkg::CMD_FREE, SW'($urandom));
                16, 17: send(ffaa_pkg::CMD_INFO, SW'($urandom));
                default: send(ffaa_pkg::CMD_RSVD, SW'($urandom));
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        send(ffaa_pkg::CMD_INFO, '0);
        send(ffaa_pkg::CMD_ALLOC, '0);
        send(ffaa_pkg::CMD_ALLOC, SW'(100));
        send(ffaa_pkg::CMD_ALLOC, SW'(8192 - 24 - 24 - 24));
        send(ffaa_pkg::CMD_ALLOC, 14'h3FFF);
        send(ffaa_pkg::CMD_FREE, SW'(24));
        send(ffaa_pkg::CMD_FREE, SW'(24));
        send(ffaa_pkg::CMD_FREE, SW'(5));
        send(ffaa_pkg::CMD_FREE, 14'h3FFF);
        send(ffaa_pkg::CMD_FREE, '0);
        send(ffaa_pkg::CMD_INFO, 14'h3FFF);
        send(ffaa_pkg::CMD_RSVD, 14'h2AAA);
        write_arena(14'h3FFF);
        send(ffaa_pkg::CMD_ALLOC, SW'(8192 - 24));
        send(ffaa_pkg::CMD_INFO, '0);
        send(ffaa_pkg::CMD_FREE, '0);
        write_arena('0);
        send(ffaa_pkg::CMD_ALLOC, SW'(76));
        send(ffaa_pkg::CMD_ALLOC, '0);
        send(ffaa_pkg::CMD_INFO, '0);
        write_arena(SW'(200));
        send(ffaa_pkg::CMD_ALLOC, SW'(10));
        send(ffaa_pkg::CMD_ALLOC, SW'(10));
        send(ffaa_pkg::CMD_FREE, '0);
        send(ffaa_pkg::CMD_FREE, SW'(58));
        send(ffaa_pkg::CMD_INFO, '0);

        write_arena(SW'(1000));
        send_idle_pct = 24;
        recv_idle_pct = 70;
        random_phase(300);
        long_hold = 1;
        random_phase(20);
        drain();
        long_hold = 0;
        send_idle_pct = 70;
        recv_idle_pct = 24;
        write_arena(SW'($urandom_range(ffaa_pkg::ARENA_BYTES, ffaa_pkg::ARENA_MIN)));
        random_phase(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_arena(SW'(ffaa_pkg::ARENA_BYTES));
        random_phase(300);
        drain();

        $display("covered %0d commands with %0d results over several arena sizes",
                 item_count, result_count);
        if (fail_count == 0)
            $display("PASS first_fit_arena_allocator");
        else
            $display("FAIL first_fit_arena_allocator");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ffaa_pkg.sv
hw/rtl/ffaa_ram.sv
hw/rtl/first_fit_arena_allocator.sv
hw/rtl/ffaa_checker.sv
tb/ffaa_checker.sv
tb/tb_first_fit_arena_allocator.sv
